// ===== hw/rtl/ssrch_pkg.sv =====
// ----------------------------------------------------------------------------
// Streaming substring search package
// Shared constants and register codes for the streaming substring search.
// ----------------------------------------------------------------------------
package ssrch_pkg;

	// Default configuration of the search engine.
	localparam int MAX_PATTERN_DEF   = 32;
	localparam int POSITION_BITS_DEF = 16;

	// Fixed widths of the stream fields and the register port.
	localparam int CHAR_BITS       = 8;
	localparam int MATCH_POS_BITS  = 16;
	localparam int DATA_BITS       = 64;
	localparam int ADDR_BITS       = 6;
	localparam int LEN_FIELD_BITS  = 6;
	localparam int NUM_PAT_WORDS   = 4;
	localparam int PAT_STORE_BITS  = NUM_PAT_WORDS * DATA_BITS;
	localparam int REG_INDEX_BITS  = 3;

	// Register indexes; each register occupies eight bytes of address space.
	localparam logic [REG_INDEX_BITS-1:0] REG_PAT_0_7   = 3'd0;
	localparam logic [REG_INDEX_BITS-1:0] REG_PAT_8_15  = 3'd1;
	localparam logic [REG_INDEX_BITS-1:0] REG_PAT_16_23 = 3'd2;
	localparam logic [REG_INDEX_BITS-1:0] REG_PAT_24_31 = 3'd3;
	localparam logic [REG_INDEX_BITS-1:0] REG_PAT_LEN   = 3'd4;

	// The text terminator.
	localparam logic [CHAR_BITS-1:0] CHAR_NUL = 8'h00;

endpackage

// ===== hw/rtl/ssrch_cfg.sv =====
// ----------------------------------------------------------------------------
// Substring search configuration registers
// Register file for the pattern and its length, plus the registered
// effective length and the byte mask of the pattern bytes in use.
// ----------------------------------------------------------------------------
module ssrch_cfg #(
	parameter int MAX_PATTERN = ssrch_pkg::MAX_PATTERN_DEF,
	parameter int LEN_BITS    = $clog2(MAX_PATTERN + 1)
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ssrch_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [ssrch_pkg::DATA_BITS-1:0]       pwdata,
	output logic [ssrch_pkg::DATA_BITS-1:0]       prdata,
	output logic                                  pready,
	output logic [MAX_PATTERN*ssrch_pkg::CHAR_BITS-1:0] pattern,
	output logic [LEN_BITS-1:0]                   eff_len,
	output logic                                  len_zero,
	output logic [MAX_PATTERN-1:0]                pat_mask
);

	localparam int LFB = ssrch_pkg::LEN_FIELD_BITS;
	localparam int CB  = ssrch_pkg::CHAR_BITS;

	logic [ssrch_pkg::NUM_PAT_WORDS-1:0][ssrch_pkg::DATA_BITS-1:0] pat_words_q;
	logic [LFB-1:0]                      pat_len_q;
	logic [ssrch_pkg::PAT_STORE_BITS-1:0] pat_flat;
	logic [ssrch_pkg::REG_INDEX_BITS-1:0] reg_index;
	logic                                wr_en;
	logic [LFB-1:0]                      len_limit;
	logic [LFB-1:0]                      len_calc;
	logic [MAX_PATTERN-1:0]              mask_calc;
	logic [LEN_BITS-1:0]                 eff_len_q;
	logic                                len_zero_q;
	logic [MAX_PATTERN-1:0]              pat_mask_q;

	assign pready    = 1'b1;
	assign reg_index = paddr[ssrch_pkg::ADDR_BITS-1:3];
	assign wr_en     = psel && penable && pwrite;
	assign pat_flat  = pat_words_q;
	assign pattern   = pat_flat[MAX_PATTERN*CB-1:0];

	// Register writes; unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_words_q <= '0;
			pat_len_q   <= '0;
		end else if (wr_en) begin
			unique case (reg_index)
				ssrch_pkg::REG_PAT_0_7:   pat_words_q[0] <= pwdata;
				ssrch_pkg::REG_PAT_8_15:  pat_words_q[1] <= pwdata;
				ssrch_pkg::REG_PAT_16_23: pat_words_q[2] <= pwdata;
				ssrch_pkg::REG_PAT_24_31: pat_words_q[3] <= pwdata;
				ssrch_pkg::REG_PAT_LEN:   pat_len_q      <= pwdata[LFB-1:0];
				default: ;
			endcase
		end
	end

	// Register reads.
	always_comb begin
		unique case (reg_index)
			ssrch_pkg::REG_PAT_0_7:   prdata = pat_words_q[0];
			ssrch_pkg::REG_PAT_8_15:  prdata = pat_words_q[1];
			ssrch_pkg::REG_PAT_16_23: prdata = pat_words_q[2];
			ssrch_pkg::REG_PAT_24_31: prdata = pat_words_q[3];
			ssrch_pkg::REG_PAT_LEN:   prdata = {{(ssrch_pkg::DATA_BITS-LFB){1'b0}}, pat_len_q};
			default:                  prdata = '0;
		endcase
	end

	// The pattern ends at its length, clamped to the window size, or at
	// its first zero byte, whichever comes first.
	always_comb begin
		len_limit = (pat_len_q > LFB'(MAX_PATTERN)) ? LFB'(MAX_PATTERN) : pat_len_q;
		len_calc  = len_limit;
		for (int k = MAX_PATTERN - 1; k >= 0; k--) begin
			if ((LFB'(k) < len_limit) && (pattern[k*CB +: CB] == ssrch_pkg::CHAR_NUL)) begin
				len_calc = LFB'(k);
			end
		end
		for (int k = 0; k < MAX_PATTERN; k++) begin
			mask_calc[k] = (LFB'(k) < len_calc);
		end
	end

	// Derived values are registered from the stored pattern and length.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_len_q  <= '0;
			len_zero_q <= 1'b1;
			pat_mask_q <= '0;
		end else begin
			eff_len_q  <= LEN_BITS'(len_calc);
			len_zero_q <= (len_calc == '0);
			pat_mask_q <= mask_calc;
		end
	end

	assign eff_len  = eff_len_q;
	assign len_zero = len_zero_q;
	assign pat_mask = pat_mask_q;

endmodule

// ===== hw/rtl/streaming_substring_search.sv =====
// Datapath: a text word passes the input register and then the result register,
// which holds the result word that the text word causes.
// Throughput: one text word per cycle while no stalled result word holds the input
// stage; the window compare and the saturating position counter update once per word.
// Reset: all control state and the pattern registers clear to zero, which
// gives an empty pattern; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Streaming substring search
// Finds the first occurrence of a configured pattern in a zero-terminated
// text stream by comparing a window of recent bytes, one byte per cycle while unstalled.
// ----------------------------------------------------------------------------
module streaming_substring_search #(
	parameter int MAX_PATTERN   = ssrch_pkg::MAX_PATTERN_DEF,
	parameter int POSITION_BITS = ssrch_pkg::POSITION_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Configuration port.
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [ssrch_pkg::ADDR_BITS-1:0]       paddr,
	input  logic [ssrch_pkg::DATA_BITS-1:0]       pwdata,
	output logic [ssrch_pkg::DATA_BITS-1:0]       prdata,
	output logic                                  pready,
	// Text stream.
	input  logic                                  text_valid,
	output logic                                  text_stall,
	input  logic [ssrch_pkg::CHAR_BITS-1:0]       text_char,
	// Result stream.
	output logic                                  result_valid,
	input  logic                                  result_stall,
	output logic                                  found,
	output logic [ssrch_pkg::MATCH_POS_BITS-1:0]  match_position
);

	localparam int CB       = ssrch_pkg::CHAR_BITS;
	localparam int LEN_BITS = $clog2(MAX_PATTERN + 1);

	logic [MAX_PATTERN*CB-1:0] pattern;
	logic [LEN_BITS-1:0]       eff_len;
	logic                      len_zero;
	logic [MAX_PATTERN-1:0]    pat_mask;

	logic                      valid_s1;
	logic [CB-1:0]             char_s1;
	logic                      advance;
	logic                      fire;
	logic                      text_accept;

	logic [MAX_PATTERN*CB-1:0] window_q;
	logic [POSITION_BITS-1:0]  count_q;
	logic                      given_q;

	logic [MAX_PATTERN*CB-1:0] window_next;
	logic [MAX_PATTERN*CB-1:0] aligned;
	logic [LEN_BITS-1:0]       shift_bytes;
	logic [MAX_PATTERN-1:0]    byte_eq;
	logic [POSITION_BITS-1:0]  count_next;
	logic [POSITION_BITS-1:0]  pos_calc;
	logic                      hit;
	logic                      is_nul;

	logic                      out_valid_q;
	logic                      found_q;
	logic [ssrch_pkg::MATCH_POS_BITS-1:0] pos_q;

	ssrch_cfg #(
		.MAX_PATTERN (MAX_PATTERN),
		.LEN_BITS    (LEN_BITS)
	) u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.pattern  (pattern),
		.eff_len  (eff_len),
		.len_zero (len_zero),
		.pat_mask (pat_mask)
	);

	// The input stage moves on whenever the result register can take a word.
	assign advance     = !out_valid_q || !result_stall;
	assign fire        = valid_s1 && advance;
	assign text_stall  = valid_s1 && !advance;
	assign text_accept = text_valid && !text_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (text_accept) begin
			char_s1 <= text_char;
		end
	end

	// The window keeps the newest byte in the top lane. Shifting it down by
	// the unused pattern slots lines the last eff_len bytes up with pattern
	// bytes 0 onward; bytes not yet seen read as zero and never match.
	always_comb begin
		is_nul      = (char_s1 == ssrch_pkg::CHAR_NUL);
		window_next = {char_s1, window_q[MAX_PATTERN*CB-1:CB]};
		shift_bytes = LEN_BITS'(MAX_PATTERN) - eff_len;
		aligned     = window_next >> (shift_bytes * CB);
		for (int k = 0; k < MAX_PATTERN; k++) begin
			byte_eq[k] = !pat_mask[k] || (aligned[k*CB +: CB] == pattern[k*CB +: CB]);
		end
		hit        = &byte_eq;
		count_next = (&count_q) ? count_q : count_q + POSITION_BITS'(1);
		pos_calc   = count_next - POSITION_BITS'(eff_len);
	end

	// Search state and result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			count_q     <= '0;
			given_q     <= 1'b0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			pos_q       <= '0;
		end else if (fire) begin
			priority if (given_q) begin
				// Swallow the rest of the text after a result.
				out_valid_q <= 1'b0;
				if (is_nul) begin
					window_q <= '0;
					count_q  <= '0;
					given_q  <= 1'b0;
				end
			end else if (len_zero) begin
				// An empty pattern matches at the start of every text.
				out_valid_q <= 1'b1;
				found_q     <= 1'b1;
				pos_q       <= '0;
				if (is_nul) begin
					window_q <= '0;
					count_q  <= '0;
				end else begin
					given_q <= 1'b1;
				end
			end else if (is_nul) begin
				// End of text without a match.
				out_valid_q <= 1'b1;
				found_q     <= 1'b0;
				pos_q       <= '0;
				window_q    <= '0;
				count_q     <= '0;
			end else begin
				window_q    <= window_next;
				count_q     <= count_next;
				out_valid_q <= hit;
				if (hit) begin
					found_q <= 1'b1;
					pos_q   <= ssrch_pkg::MATCH_POS_BITS'(pos_calc);
					given_q <= 1'b1;
				end
			end
		end else if (advance) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid   = out_valid_q;
	assign found          = found_q;
	assign match_position = pos_q;

endmodule

// ===== hw/rtl/ssrch_checker.sv =====
// ----------------------------------------------------------------------------
// Substring search port checker
// Watches the stream ports of the substring search and flags violations.
// ----------------------------------------------------------------------------
module ssrch_checker (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 text_valid,
	input logic                                 text_stall,
	input logic                                 result_valid,
	input logic                                 result_stall,
	input logic                                 found,
	input logic [ssrch_pkg::MATCH_POS_BITS-1:0] match_position
);

	// A stalled result word stays and holds its payload.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(found)
			&& $stable(match_position))
		else $error("result word changed while stalled");

	// The text side only stalls when a result word is waiting and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		text_stall |-> result_valid && result_stall)
		else $error("text stalled without a stalled result");

	// A miss always reports position zero.
	a_miss_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !found |-> match_position == '0)
		else $error("miss reported with a nonzero position");

endmodule

bind streaming_substring_search ssrch_checker u_ssrch_checker (.*);
